// File: rtl/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared widths, register indexes and status codes of the first-fit
// page allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

    localparam int PAGES_DEFAULT = 1024;
    localparam int SLOTS_DEFAULT = 64;

    // 4 KiB pages
    localparam int PAGE_SHIFT = 12;

    localparam int ADDR_W        = 32;
    localparam int ALLOC_SIZE_W  = 31;
    localparam int BASE_PAGE_W   = ADDR_W - PAGE_SHIFT;
    localparam int USABLE_W      = 11;
    localparam int STATUS_W      = 2;
    localparam int NEED_W        = ALLOC_SIZE_W - PAGE_SHIFT + 1;

    localparam logic [USABLE_W-1:0] USABLE_RESET = USABLE_W'(1024);

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = BASE_PAGE_W;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_PAGE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USABLE_PAGES = 1'd1;

    // request codes
    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    // response status codes
    localparam logic [STATUS_W-1:0] STAT_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_SLOT      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_OUT_OF_PAGES = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND    = 2'd3;

endpackage

// File: rtl/ffpa_req_if.sv
// ----------------------------------------------------------------------------
// ffpa_req_if
// Request channel of the page allocator: valid/ready plus request payload.
// ----------------------------------------------------------------------------
interface ffpa_req_if;
    import ffpa_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    func;
    logic [ALLOC_SIZE_W-1:0] alloc_size;
    logic [ADDR_W-1:0]       release_address;

    modport source (
        output valid,
        output func,
        output alloc_size,
        output release_address,
        input  ready
    );

    modport sink (
        input  valid,
        input  func,
        input  alloc_size,
        input  release_address,
        output ready
    );

endinterface

// File: rtl/ffpa_rsp_if.sv
// ----------------------------------------------------------------------------
// ffpa_rsp_if
// Response channel of the page allocator: valid/ready plus result payload.
// ----------------------------------------------------------------------------
interface ffpa_rsp_if;
    import ffpa_pkg::*;

    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   result_address;
    logic [STATUS_W-1:0] status;

    modport source (
        output valid,
        output result_address,
        output status,
        input  ready
    );

    modport sink (
        input  valid,
        input  result_address,
        input  status,
        output ready
    );

endinterface

// File: rtl/first_fit_page_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_page_allocator
// First-fit contiguous page allocator with a slot table and a free-page map.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass that marks every page free and
// every slot empty; requests are held off until it is done. Each request then
// reads one table entry per cycle through single-port-read RAMs. An allocate
// scans the slot table up to the first empty slot, computes the page count,
// scans the page map first-fit over the usable pages, then marks each
// allocated page used. A release scans the slot table for the matching
// address and marks each freed page free. The response is then presented and
// holds until taken. Configuration is written through cfg_we / cfg_index /
// cfg_wdata; the user must write it only while no request is active, as the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module first_fit_page_allocator #(
    parameter int PAGES = ffpa_pkg::PAGES_DEFAULT,
    parameter int SLOTS = ffpa_pkg::SLOTS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ffpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ffpa_pkg::CFG_DATA_W-1:0] cfg_wdata,
    ffpa_req_if.sink                        req,
    ffpa_rsp_if.source                      rsp
);
    import ffpa_pkg::*;

    localparam int PAGE_AW = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LIM_W   = $clog2(PAGES + 1);
    localparam int SCAN_W  = (PAGE_AW > SLOT_AW) ? PAGE_AW : SLOT_AW;
    localparam int CLR_N   = (PAGES > SLOTS) ? PAGES : SLOTS;
    localparam int CLR_AW  = (CLR_N > 1) ? $clog2(CLR_N) : 1;
    localparam int SLOT_W  = 1 + 2 * PAGE_AW;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SLOT  = 4'd2;
    localparam logic [3:0] S_SIZE  = 4'd3;
    localparam logic [3:0] S_PAGE  = 4'd4;
    localparam logic [3:0] S_REL   = 4'd5;
    localparam logic [3:0] S_MARK  = 4'd6;
    localparam logic [3:0] S_RESP  = 4'd7;

    // control state
    logic [3:0]        state_reg, state_next;
    logic [CLR_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [SCAN_W-1:0] cnt_reg, cnt_next;
    logic              pend_reg, pend_next;
    logic [SCAN_W-1:0] pidx_reg, pidx_next;

    // configuration
    logic [BASE_PAGE_W-1:0] base_page_reg;
    logic [USABLE_W-1:0]    usable_pages_reg;

    // request and working payload
    logic                    func_reg, func_next;
    logic [ALLOC_SIZE_W-1:0] size_reg, size_next;
    logic [ADDR_W-1:0]       rel_addr_reg, rel_addr_next;
    logic [LIM_W-1:0]        run_reg, run_next;
    logic [NEED_W-1:0]       need_reg, need_next;
    logic [SLOT_AW-1:0]      slot_reg, slot_next;
    logic [PAGE_AW-1:0]      start_reg, start_next;
    logic [PAGE_AW-1:0]      end_reg, end_next;
    logic [PAGE_AW-1:0]      mark_cnt_reg, mark_cnt_next;
    logic                    mark_val_reg, mark_val_next;
    logic [ADDR_W-1:0]       rsp_addr_reg, rsp_addr_next;
    logic [STATUS_W-1:0]     rsp_status_reg, rsp_status_next;

    // memories
    logic               page_we;
    logic [PAGE_AW-1:0] page_waddr;
    logic               page_wdata;
    logic [PAGE_AW-1:0] page_raddr;
    logic               page_rdata;
    logic               slot_we;
    logic [SLOT_AW-1:0] slot_waddr;
    logic [SLOT_W-1:0]  slot_wdata;
    logic [SLOT_AW-1:0] slot_raddr;
    logic [SLOT_W-1:0]  slot_rdata;

    logic               slot_valid;
    logic [PAGE_AW-1:0] slot_start;
    logic [PAGE_AW-1:0] slot_end;

    logic [PAGE_AW-1:0] unit_start;
    logic [ADDR_W-1:0]  unit_addr;
    logic               unit_match;

    logic [31:0]        usable_ext;
    logic [LIM_W-1:0]   limit;
    logic [NEED_W-1:0]  need_calc;
    logic               slot_last_issue, slot_last;
    logic               page_last_issue, page_last;
    logic [PAGE_AW-1:0] run_start;

    ffpa_ram #(
        .WIDTH (1),
        .DEPTH (PAGES),
        .AW    (PAGE_AW)
    ) u_page_ram (
        .clk   (clk),
        .we    (page_we),
        .waddr (page_waddr),
        .wdata (page_wdata),
        .raddr (page_raddr),
        .rdata (page_rdata)
    );

    ffpa_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS),
        .AW    (SLOT_AW)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    ffpa_addr_unit #(
        .START_W (PAGE_AW)
    ) u_addr_unit (
        .base_page (base_page_reg),
        .start     (unit_start),
        .target    (rel_addr_reg),
        .addr      (unit_addr),
        .match     (unit_match)
    );

    assign slot_valid = slot_rdata[SLOT_W-1];
    assign slot_start = slot_rdata[2*PAGE_AW-1:PAGE_AW];
    assign slot_end   = slot_rdata[PAGE_AW-1:0];

    assign unit_start = (state_reg == S_MARK) ? start_reg : slot_start;

    // scan limit: usable pages, capped at the map size
    assign usable_ext = 32'(usable_pages_reg);
    assign limit      = (usable_ext > 32'(PAGES)) ? LIM_W'(PAGES) : LIM_W'(usable_ext);

    // bytes rounded up to whole pages
    assign need_calc = NEED_W'(size_reg[ALLOC_SIZE_W-1:PAGE_SHIFT])
                     + NEED_W'(|size_reg[PAGE_SHIFT-1:0]);

    assign slot_last_issue = (32'(cnt_reg[SLOT_AW-1:0]) == 32'(SLOTS - 1));
    assign slot_last       = (32'(pidx_reg[SLOT_AW-1:0]) == 32'(SLOTS - 1));
    assign page_last_issue = (32'(cnt_reg[PAGE_AW-1:0]) == 32'(limit) - 32'd1);
    assign page_last       = (32'(pidx_reg[PAGE_AW-1:0]) == 32'(limit) - 32'd1);
    assign run_start       = pidx_reg[PAGE_AW-1:0] - PAGE_AW'(run_reg);

    assign page_raddr = cnt_reg[PAGE_AW-1:0];
    assign slot_raddr = cnt_reg[SLOT_AW-1:0];

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = (state_reg == S_RESP);
    assign rsp.result_address = rsp_addr_reg;
    assign rsp.status         = rsp_status_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        cnt_next        = cnt_reg;
        pend_next       = 1'b0;
        pidx_next       = cnt_reg;
        func_next       = func_reg;
        size_next       = size_reg;
        rel_addr_next   = rel_addr_reg;
        run_next        = run_reg;
        need_next       = need_reg;
        slot_next       = slot_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        mark_cnt_next   = mark_cnt_reg;
        mark_val_next   = mark_val_reg;
        rsp_addr_next   = rsp_addr_reg;
        rsp_status_next = rsp_status_reg;

        page_we    = 1'b0;
        page_waddr = mark_cnt_reg;
        page_wdata = mark_val_reg;
        slot_we    = 1'b0;
        slot_waddr = slot_reg;
        slot_wdata = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                page_we      = (32'(clr_cnt_reg) < 32'(PAGES));
                page_waddr   = clr_cnt_reg[PAGE_AW-1:0];
                page_wdata   = 1'b1;
                slot_we      = (32'(clr_cnt_reg) < 32'(SLOTS));
                slot_waddr   = clr_cnt_reg[SLOT_AW-1:0];
                slot_wdata   = '0;
                clr_cnt_next = clr_cnt_reg + CLR_AW'(1);
                if (32'(clr_cnt_reg) == 32'(CLR_N - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next     = req.func;
                    size_next     = req.alloc_size;
                    rel_addr_next = req.release_address;
                    cnt_next      = '0;
                    state_next    = (req.func == FUNC_RELEASE) ? S_REL : S_SLOT;
                end
            end

            S_SLOT:
            begin
                // one slot read issued per cycle, its data checked in the next cycle
                pend_next = 1'b1;
                cnt_next  = slot_last_issue ? cnt_reg : cnt_reg + SCAN_W'(1);
                if (pend_reg)
                begin
                    if (!slot_valid)
                    begin
                        slot_next  = pidx_reg[SLOT_AW-1:0];
                        state_next = S_SIZE;
                    end
                    else if (slot_last)
                    begin
                        rsp_addr_next   = '0;
                        rsp_status_next = STAT_NO_SLOT;
                        state_next      = S_RESP;
                    end
                end
            end

            S_SIZE:
            begin
                need_next = need_calc;
                cnt_next  = '0;
                run_next  = '0;
                if (need_calc == '0 || 32'(need_calc) > 32'(limit))
                begin
                    rsp_addr_next   = '0;
                    rsp_status_next = STAT_OUT_OF_PAGES;
                    state_next      = S_RESP;
                end
                else
                begin
                    state_next = S_PAGE;
                end
            end

            S_PAGE:
            begin
                pend_next = 1'b1;
                cnt_next  = page_last_issue ? cnt_reg : cnt_reg + SCAN_W'(1);
                if (pend_reg)
                begin
                    if (page_rdata && (32'(run_reg) + 32'd1 == 32'(need_reg)))
                    begin
                        start_next    = run_start;
                        end_next      = pidx_reg[PAGE_AW-1:0];
                        mark_cnt_next = run_start;
                        mark_val_next = 1'b0;
                        slot_we       = 1'b1;
                        slot_waddr    = slot_reg;
                        slot_wdata    = {1'b1, run_start, pidx_reg[PAGE_AW-1:0]};
                        state_next    = S_MARK;
                    end
                    else
                    begin
                        run_next = page_rdata ? run_reg + LIM_W'(1) : '0;
                        if (page_last)
                        begin
                            rsp_addr_next   = '0;
                            rsp_status_next = STAT_OUT_OF_PAGES;
                            state_next      = S_RESP;
                        end
                    end
                end
            end

            S_REL:
            begin
                pend_next = 1'b1;
                cnt_next  = slot_last_issue ? cnt_reg : cnt_reg + SCAN_W'(1);
                if (pend_reg)
                begin
                    if (slot_valid && unit_match)
                    begin
                        slot_we       = 1'b1;
                        slot_waddr    = pidx_reg[SLOT_AW-1:0];
                        slot_wdata    = '0;
                        mark_cnt_next = slot_start;
                        end_next      = slot_end;
                        mark_val_next = 1'b1;
                        state_next    = S_MARK;
                    end
                    else if (slot_last)
                    begin
                        rsp_addr_next   = '0;
                        rsp_status_next = STAT_NOT_FOUND;
                        state_next      = S_RESP;
                    end
                end
            end

            S_MARK:
            begin
                page_we       = 1'b1;
                page_waddr    = mark_cnt_reg;
                page_wdata    = mark_val_reg;
                mark_cnt_next = mark_cnt_reg + PAGE_AW'(1);
                if (mark_cnt_reg == end_reg)
                begin
                    rsp_addr_next   = (func_reg == FUNC_RELEASE) ? '0 : unit_addr;
                    rsp_status_next = STAT_OK;
                    state_next      = S_RESP;
                end
            end

            S_RESP:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_page_reg    <= '0;
            usable_pages_reg <= USABLE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BASE_PAGE:    base_page_reg    <= cfg_wdata[BASE_PAGE_W-1:0];
                CFG_USABLE_PAGES: usable_pages_reg <= cfg_wdata[USABLE_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg       <= pidx_next;
        func_reg       <= func_next;
        size_reg       <= size_next;
        rel_addr_reg   <= rel_addr_next;
        run_reg        <= run_next;
        need_reg       <= need_next;
        slot_reg       <= slot_next;
        start_reg      <= start_next;
        end_reg        <= end_next;
        mark_cnt_reg   <= mark_cnt_next;
        mark_val_reg   <= mark_val_next;
        rsp_addr_reg   <= rsp_addr_next;
        rsp_status_reg <= rsp_status_next;
    end

    // a request is never taken while a response is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && rsp.valid))
        else $error("request accepted while response pending");

    // only a successful allocate carries an address
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != STAT_OK |-> rsp.result_address == '0)
        else $error("failed request returned a nonzero address");

    // the page walk never runs past the end of its run
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MARK |-> mark_cnt_reg <= end_reg)
        else $error("page marking ran past the end page");

    // an accepted request is never answered in the very next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !rsp.valid)
        else $error("response raised without any table scan");

endmodule

// File: rtl/ffpa_ram.sv
// ----------------------------------------------------------------------------
// ffpa_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module ffpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/ffpa_addr_unit.sv
// ----------------------------------------------------------------------------
// ffpa_addr_unit
// Shared address unit: turns a start page into a physical address under the
// current base page and compares it against a target address.
// ----------------------------------------------------------------------------
module ffpa_addr_unit #(
    parameter int START_W = 10
) (
    input  logic [ffpa_pkg::BASE_PAGE_W-1:0] base_page,
    input  logic [START_W-1:0]               start,
    input  logic [ffpa_pkg::ADDR_W-1:0]      target,
    output logic [ffpa_pkg::ADDR_W-1:0]      addr,
    output logic                             match
);
    import ffpa_pkg::*;

    logic [BASE_PAGE_W-1:0] page_num;

    // the sum wraps in the page field, which gives the address modulo 2^32
    assign page_num = base_page + BASE_PAGE_W'(start);
    assign addr     = {page_num, {PAGE_SHIFT{1'b0}}};
    assign match    = (addr == target);

endmodule
